>>> rtl/core/mmoq_pkg.sv
// Shared types and codes of the merging outbound chunk queue.
package mmoq_pkg;

  // Operation codes of an input transaction.
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // Width of the batch size register.
  localparam int unsigned BATCH_REG_W = 5;
  localparam logic [BATCH_REG_W-1:0] BATCH_RESET = 5'd8;

  // Kind of a result transaction.
  typedef enum logic [1:0] {
    KIND_APPENDED = 2'd0,
    KIND_MERGED   = 2'd1,
    KIND_DROPPED  = 2'd2,
    KIND_SENT     = 2'd3
  } kind_t;

  // One input transaction.
  typedef struct packed {
    logic        opcode;
    logic [63:0] sid;
    logic [63:0] rid;
    logic [63:0] vrid;
    logic [63:0] fid;
    logic [31:0] seqnum;
  } item_t;

  // One result transaction.
  typedef struct packed {
    kind_t       kind;
    logic [63:0] out_sid;
    logic [63:0] out_rid;
    logic [63:0] out_vrid;
    logic [63:0] out_fid;
    logic [31:0] out_seqnum;
    logic        last;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  capture;
    logic  srch_clear;
    logic  srch_read;
    logic  merge_wr;
    logic  append_wr;
    logic  send_load;
    logic  pop_read;
    logic  emit;
    kind_t kind;
    logic  last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic seq_zero;
    logic occ_zero;
    logic full;
    logic srch_end;
    logic match;
    logic send_zero;
    logic send_one;
  } dp_status_t;

endpackage

>>> rtl/core/mmoq_ctrl.sv
// Controller state machine of the merging outbound chunk queue.
module mmoq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mmoq_pkg::dp_status_t sts,
  output mmoq_pkg::dp_cmd_t    cmd
);
  import mmoq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SEARCH,
    ST_FINISH,
    ST_SEND,
    ST_TAIL
  } state_t;

  state_t state;
  state_t state_next;
  logic   cmp_v;
  logic   pend_v;

  // Next state and commands for the current cycle.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.kind   = KIND_APPENDED;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.is_tick) begin
          cmd.send_load = 1'b1;
          state_next    = sts.send_zero ? ST_IDLE : ST_SEND;
        end else if (!sts.seq_zero && !sts.occ_zero) begin
          cmd.srch_clear = 1'b1;
          state_next     = ST_SEARCH;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SEARCH: begin
        // The entry read in the previous cycle is compared in this one.
        if (cmp_v && sts.match) begin
          cmd.merge_wr = 1'b1;
          cmd.emit     = 1'b1;
          cmd.kind     = KIND_MERGED;
          cmd.last     = 1'b1;
          state_next   = ST_IDLE;
        end else if (sts.srch_end) begin
          state_next = ST_FINISH;
        end else begin
          cmd.srch_read = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd.emit = 1'b1;
        cmd.last = 1'b1;
        if (sts.full) begin
          cmd.kind = KIND_DROPPED;
        end else begin
          cmd.append_wr = 1'b1;
          cmd.kind      = KIND_APPENDED;
        end
        state_next = ST_IDLE;
      end
      ST_SEND: begin
        // Pop one head entry a cycle; each is emitted in the cycle after its pop.
        cmd.pop_read = 1'b1;
        cmd.emit     = pend_v;
        cmd.kind     = KIND_SENT;
        if (sts.send_one) begin
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: begin
        cmd.emit   = 1'b1;
        cmd.kind   = KIND_SENT;
        cmd.last   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      busy   <= 1'b0;
      cmp_v  <= 1'b0;
      pend_v <= 1'b0;
    end else begin
      state  <= state_next;
      busy   <= (state_next != ST_IDLE);
      cmp_v  <= cmd.srch_read;
      pend_v <= cmd.pop_read;
    end
  end

endmodule

>>> rtl/core/mmoq_datapath.sv
// Datapath of the merging outbound chunk queue: entry memory, pointers, compare and output.
module mmoq_datapath #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 64,
  parameter int unsigned FID_WIDTH   = 64,
  parameter int unsigned MAX_BATCH   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mmoq_pkg::item_t                      item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mmoq_pkg::BATCH_REG_W-1:0]     cfg_data,
  input  mmoq_pkg::dp_cmd_t                    cmd,
  output mmoq_pkg::dp_status_t                 sts,
  output mmoq_pkg::result_t                    result,
  output logic                                 result_valid
);
  import mmoq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned OW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned BW = $clog2(MAX_BATCH + 1);
  // Layout of one stored entry: sid, rid, vrid, fid, seq from top to bottom.
  localparam int unsigned SEQ_LSB  = 0;
  localparam int unsigned FID_LSB  = 32;
  localparam int unsigned VRID_LSB = FID_LSB + FID_WIDTH;
  localparam int unsigned RID_LSB  = VRID_LSB + ID_WIDTH;
  localparam int unsigned SID_LSB  = RID_LSB + ID_WIDTH;
  localparam int unsigned EW       = SID_LSB + ID_WIDTH;

  logic                   op_q;
  logic [ID_WIDTH-1:0]    sid_q;
  logic [ID_WIDTH-1:0]    rid_q;
  logic [ID_WIDTH-1:0]    vrid_q;
  logic [FID_WIDTH-1:0]   fid_q;
  logic [31:0]            seq_q;
  logic [BATCH_REG_W-1:0] batch_size;
  logic [AW-1:0]          head;
  logic [OW-1:0]          occ;
  logic [OW-1:0]          rd_cnt;
  logic [BW-1:0]          send_left;
  logic [AW-1:0]          rd_slot_q;
  logic [EW-1:0]          rdata;
  logic [EW-1:0]          mem [QUEUE_DEPTH];

  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [EW-1:0]          wr_data;
  logic [31:0]            batch_sat;
  logic [31:0]            send_n;
  logic                   is_sent;

  // Slot that lies a given number of entries past the head.
  function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] base,
                                            input logic [OW-1:0] off);
    logic [OW:0] s;
    s = (OW+1)'(base) + (OW+1)'(off);
    if (s >= (OW+1)'(QUEUE_DEPTH)) begin
      s = s - (OW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // The register port never stalls.
  assign cfg_ready = 1'b1;

  // Batch size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_size <= BATCH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      batch_size <= cfg_data;
    end
  end

  // Captured transaction, narrowed to the configured widths.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= item.opcode;
      sid_q  <= item.sid[ID_WIDTH-1:0];
      rid_q  <= item.rid[ID_WIDTH-1:0];
      vrid_q <= item.vrid[ID_WIDTH-1:0];
      fid_q  <= item.fid[FID_WIDTH-1:0];
      seq_q  <= item.seqnum;
    end
  end

  // Number of entries a tick sends: batch size capped by the limit and by the fill.
  always_comb begin
    batch_sat = (32'(batch_size) > 32'(MAX_BATCH)) ? 32'(MAX_BATCH) : 32'(batch_size);
    send_n    = (batch_sat > 32'(occ)) ? 32'(occ) : batch_sat;
  end

  // Memory port selection.
  always_comb begin
    rd_en   = cmd.srch_read || cmd.pop_read;
    rd_addr = cmd.pop_read ? head : slot_at(head, rd_cnt);
    wr_en   = cmd.merge_wr || cmd.append_wr;
    wr_addr = cmd.merge_wr ? rd_slot_q : slot_at(head, occ);
    if (cmd.merge_wr) begin
      wr_data = rdata;
      wr_data[FID_LSB +: FID_WIDTH] = rdata[FID_LSB +: FID_WIDTH] | fid_q;
    end else begin
      wr_data = {sid_q, rid_q, vrid_q, fid_q, seq_q};
    end
  end

  // Entry memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata     <= mem[rd_addr];
      rd_slot_q <= rd_addr;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      occ  <= '0;
    end else if (cmd.pop_read) begin
      head <= (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
      occ  <= occ - 1'b1;
    end else if (cmd.append_wr) begin
      occ <= occ + 1'b1;
    end
  end

  // Search and send counters.
  always_ff @(posedge clk) begin
    if (cmd.srch_clear) begin
      rd_cnt <= '0;
    end else if (cmd.srch_read) begin
      rd_cnt <= rd_cnt + 1'b1;
    end
    if (cmd.send_load) begin
      send_left <= BW'(send_n);
    end else if (cmd.pop_read) begin
      send_left <= send_left - 1'b1;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.is_tick   = (op_q == OP_TICK);
    sts.seq_zero  = (seq_q == '0);
    sts.occ_zero  = (occ == '0);
    sts.full      = (occ == OW'(QUEUE_DEPTH));
    sts.srch_end  = (rd_cnt == occ);
    sts.match     = (rdata[SEQ_LSB +: 32] == seq_q) &&
                    (rdata[VRID_LSB +: ID_WIDTH] == vrid_q) &&
                    (rdata[RID_LSB +: ID_WIDTH] == rid_q) &&
                    (rdata[SID_LSB +: ID_WIDTH] == sid_q);
    sts.send_zero = (send_n == '0);
    sts.send_one  = (send_left == BW'(1));
  end

  assign is_sent = (cmd.kind == KIND_SENT);

  // Result register; fields other than kind and last are zero unless an entry is sent.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
    if (cmd.emit) begin
      result.kind       <= cmd.kind;
      result.last       <= cmd.last;
      result.out_sid    <= is_sent ? 64'(rdata[SID_LSB +: ID_WIDTH]) : '0;
      result.out_rid    <= is_sent ? 64'(rdata[RID_LSB +: ID_WIDTH]) : '0;
      result.out_vrid   <= is_sent ? 64'(rdata[VRID_LSB +: ID_WIDTH]) : '0;
      result.out_fid    <= is_sent ? 64'(rdata[FID_LSB +: FID_WIDTH]) : '0;
      result.out_seqnum <= is_sent ? rdata[SEQ_LSB +: 32] : '0;
    end
  end

endmodule

>>> rtl/core/multicast_merging_out_queue_core.sv
// Top level of the merging outbound chunk queue.
//
// An input transaction is taken when start is high and busy is low. Opcode
// enqueue searches the queued entries from head to tail for the same nonzero
// sequence number and identifiers; the earliest match gets the new forwarding
// mask ORed in (merged), otherwise the chunk is appended, or dropped if the
// queue is full. Each enqueue gives one result with last set. No search runs
// when the sequence number is zero or the queue is empty; otherwise the single
// read port gives one entry a cycle and each compare uses the registered read
// data of its read. Opcode tick pops up to batch_size head entries, capped at
// MAX_BATCH and at the fill, and sends them on consecutive cycles; last marks
// the final one. A tick with nothing to send (empty queue or batch size zero)
// gives no result and holds busy for one cycle.
// Each result is shown for one cycle on result, marked by result_valid; the
// receiver cannot stall. busy falls together with the final result, so the
// next transaction is taken at the earliest at the edge that ends it.
// The batch size register is to be written over cfg_valid/cfg_ready only
// while the block is idle; the block itself does not enforce this. Reset
// empties the queue and sets batch_size to 8.
module multicast_merging_out_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 64,
  parameter int unsigned FID_WIDTH   = 64,
  parameter int unsigned MAX_BATCH   = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  mmoq_pkg::item_t                  item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mmoq_pkg::BATCH_REG_W-1:0] cfg_data,
  output mmoq_pkg::result_t                result,
  output logic                             result_valid
);
  import mmoq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  // Sequencing of the search, append and send steps.
  mmoq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start && !busy),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Entry storage, pointers and result register.
  mmoq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH),
    .FID_WIDTH   (FID_WIDTH),
    .MAX_BATCH   (MAX_BATCH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

>>> rtl/core/mmoq_checker.sv
// Port-level checks of the merging outbound chunk queue and their binding.
module mmoq_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input mmoq_pkg::result_t result,
  input logic              result_valid
);
  import mmoq_pkg::*;

  // An accepted transaction makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // The final result of a transaction leaves the block idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> !busy)
    else $error("busy still high with the final result");

  // A sent entry that is not the final one keeps the block busy.
  a_sent_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy && result.kind == KIND_SENT)
    else $error("non-final result that is not a sent entry");

  // An enqueue outcome is a single result with empty chunk fields.
  a_enq_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind != KIND_SENT |->
      result.last && result.out_sid == '0 && result.out_rid == '0 &&
      result.out_vrid == '0 && result.out_fid == '0 && result.out_seqnum == '0)
    else $error("enqueue result with chunk fields or without last");

endmodule

bind multicast_merging_out_queue_core mmoq_checker u_mmoq_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result       (result),
  .result_valid (result_valid)
);
